// ===== hw/rtl/tafd_pkg.sv =====
// tafd_pkg: shared types and constants of the timer audio frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package tafd_pkg;

  localparam int unsigned PowerFloor = 107374;
  localparam int unsigned RunMax     = 24'hFF_FFFF;
  localparam int unsigned BitCap     = 128;
  localparam int unsigned SameLimit  = 100;
  localparam logic [7:0]  ChrA       = 8'h41;
  localparam logic [7:0]  ChrC       = 8'h43;
  localparam logic [7:0]  ChrL       = 8'h4C;
  localparam logic [7:0]  ChrR       = 8'h52;
  localparam logic [7:0]  ChrS       = 8'h53;
  localparam logic [7:0]  ChrSpace   = 8'h20;

  localparam logic [2:0] RegBaud  = 3'd0;
  localparam logic [2:0] RegAgc   = 3'd1;
  localparam logic [2:0] RegEdge  = 3'd2;
  localparam logic [2:0] RegLevel = 3'd3;
  localparam logic [2:0] RegTaps  = 3'd4;

  typedef struct packed {
    logic [7:0]  hdr;
    logic        on;
    logic        green;
    logic        left;
    logic        right;
    logic        running;
    logic        updated;
  } status_t;

endpackage

// ===== hw/rtl/tafd_div.sv =====
// tafd_div: shared restoring divider, one quotient bit per cycle.
// Depends on nothing; used for the divides of the top (the integer square root is stepped in the top).
`timescale 1ns / 1ps

module tafd_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  num_q, quo_q;
  logic [W-1:0]  den_q;
  logic [W:0]    rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    trial;

  assign trial = {rem_q[W-1:0], num_q[W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        num_q <= num_q << 1;
        if (trial >= {1'b0, den_q}) begin
          rem_q <= trial - {1'b0, den_q};
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hw/rtl/timer_audio_frame_decoder_top.sv =====
// timer_audio_frame_decoder_top: sequencer for gain control, edge test and packet decode.
// Depends on tafd_pkg and tafd_div; the root is stepped here, the divides use the shared divider.
// A run-out bit adds a bit step; an edge adds the bit-count divide and a step per bit.
// Bits per edge are capped at 128.
// New samples wait until the last word is produced; a stalled result holds only the next result.
// Reset (rst_ni low, async): registers to defaults, power to 1.0, decoder state cleared.
`timescale 1ns / 1ps

module timer_audio_frame_decoder_top #(
  parameter int unsigned MAX_DELAY    = 16,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned PACKET_BYTES = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_addr_i,
  input  logic [15:0]            cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // sample [SAMPLE_BITS-1:0], zero fill to bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // header_byte[7:0], time_ms[32:8], power_on[33], green_light[34], left_hand[35],
  // right_hand[36], running[37], updated[38], zero fill [39]
  output logic [39:0]            m_axis_tdata
);

  localparam int unsigned DW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int unsigned TW = $clog2(MAX_DELAY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_PROD, S_POW, S_SQRT, S_NDIV, S_NWAIT, S_EDGE, S_BDIV, S_BWAIT, S_BITS,
    S_BIT, S_SUM, S_OUT
  } state_e;

  state_e state_q;

  logic [15:0] spb_q, agc_q;
  logic [14:0] eth_q, lth_q;
  logic [4:0]  taps_q;

  logic [31:0] pow_q;
  logic signed [15:0] dly_q [MAX_DELAY];
  logic [DW-1:0] ptr_q;
  logic        lvl_q, idle_q;
  logic [23:0] run_q;
  logic [15:0] same_q;
  logic [9:0]  sh_q;
  logic [7:0]  pk_q [PACKET_BYTES];
  logic [3:0]  bc_q;
  tafd_pkg::status_t st_q;
  logic signed [24:0] tv_q;
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic [31:0] sq_q;
  logic signed [50:0] prod_q;
  logic [31:0] rx_q, rres_q, rbit_q;
  logic [4:0]  rstep_q;
  logic signed [15:0] v_q;
  logic [7:0]  nbits_q;
  logic        neg_q, mode_q;
  logic [39:0] out_q;
  logic        ovalid_q;

  // divider
  logic        dv_start, dv_done;
  logic [31:0] dv_num, dv_den, dv_quo;

  tafd_div #(.W(32)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  logic [16:0] spb1;
  assign spb1 = (spb_q == 16'd0) ? 17'd1 : {1'b0, spb_q};
  logic [TW-1:0] taps_eff;
  always_comb begin
    if (taps_q == 5'd0) taps_eff = TW'(1);
    else if (32'(taps_q) > MAX_DELAY) taps_eff = TW'(MAX_DELAY);
    else taps_eff = TW'(taps_q);
  end

  // power update
  logic [SAMPLE_BITS*2-1:0] sqw;
  logic [31:0] sq30;
  logic signed [33:0] pdiff;
  logic signed [50:0] pprod;
  logic signed [34:0] pnew;
  logic [50:0] pmag;
  assign sqw = (SAMPLE_BITS*2)'($signed(s_q) * $signed(s_q));
  always_comb begin
    if (2*(SAMPLE_BITS-1) >= 30) sq30 = 32'(sqw >> (2*(SAMPLE_BITS-1) - 30));
    else sq30 = 32'(sqw << (30 - 2*(SAMPLE_BITS-1)));
  end
  assign pdiff = $signed({2'b0, sq_q}) - $signed({2'b0, pow_q});
  assign pprod = 51'(pdiff) * $signed({1'b0, agc_q});
  assign pmag  = prod_q[50] ? 51'(-prod_q) : 51'(prod_q);
  always_comb begin
    if (!prod_q[50]) pnew = $signed({3'b0, pow_q}) + $signed(35'(pmag >> 16));
    else pnew = $signed({3'b0, pow_q}) - $signed(35'((pmag + 51'd65535) >> 16));
  end

  // sqrt step
  logic [31:0] rsum;
  assign rsum = rres_q + rbit_q;

  // edge
  logic signed [16:0] dv, swing, lvv;
  logic               edge_w;
  logic [27:0] run10, spb6;
  assign dv    = 17'(dly_q[ptr_q]);
  assign swing = lvl_q ? (dv - 17'(v_q)) : (17'(v_q) - dv);
  assign lvv   = lvl_q ? -17'(v_q) : 17'(v_q);
  assign run10 = 28'(run_q) * 28'd10;
  assign spb6  = 28'(spb1) * 28'd6;
  assign edge_w = (swing > $signed({2'b0, eth_q})) && (lvv > $signed({2'b0, lth_q}))
                  && (run10 > spb6);

  // run length steps
  logic [24:0] run_inc, run_dec;
  assign run_inc = 25'(run_q) + 25'd256;
  assign run_dec = 25'(run_q) - 25'(spb1) + 25'd256;

  // normalize sample
  logic [31:0] sabs;
  logic signed [SAMPLE_BITS:0] sx;
  assign sx   = SAMPLE_BITS'(0) + (SAMPLE_BITS+1)'(s_q);
  assign sabs = 32'(sx[SAMPLE_BITS] ? -sx : sx) << (28 - SAMPLE_BITS);

  // bit decode combinational
  logic        bit_w;
  logic [15:0] same_n;
  logic [9:0]  sh_n, xw;
  logic        idle_n, silence, frame;
  logic [3:0]  bc_n;
  assign bit_w  = lvl_q;
  always_comb begin
    if (bit_w == sh_q[9]) same_n = (same_q < 16'hFFFF) ? same_q + 16'd1 : same_q;
    else same_n = 16'd1;
    sh_n    = {bit_w, sh_q[9:1]};
    silence = (same_n > 16'(tafd_pkg::SameLimit));
    idle_n  = idle_q;
    bc_n    = bc_q;
    if (sh_n == 10'd0 || sh_n == 10'h3FF) begin
      idle_n = bit_w;
      bc_n   = 4'd0;
    end
    xw    = sh_n ^ (idle_n ? 10'd0 : 10'h3FF);
    frame = (xw[9] && !xw[0]);
  end

  // packet evaluation
  logic signed [11:0] sum9, sum10;
  logic signed [24:0] t9, t10;
  function automatic logic signed [24:0] dg(input logic [7:0] b);
    return 25'($signed({1'b0, b}) - 9'sd48);
  endfunction
  assign sum9  = 12'sd64 - 12'sd240 + 12'(pk_q[1]) + 12'(pk_q[2]) + 12'(pk_q[3])
                 + 12'(pk_q[4]) + 12'(pk_q[5]);
  assign sum10 = 12'sd64 - 12'sd288 + 12'(pk_q[1]) + 12'(pk_q[2]) + 12'(pk_q[3])
                 + 12'(pk_q[4]) + 12'(pk_q[5]) + 12'(pk_q[6]);
  assign t9 = dg(pk_q[1]) * 25'sd60000 + dg(pk_q[2]) * 25'sd10000 + dg(pk_q[3]) * 25'sd1000
              + dg(pk_q[4]) * 25'sd100 + dg(pk_q[5]) * 25'sd10;
  assign t10 = t9 + dg(pk_q[6]);

  function automatic tafd_pkg::status_t mk_status(input logic [7:0] h, input logic signed [24:0] t,
      input tafd_pkg::status_t old, input logic signed [24:0] told);
    tafd_pkg::status_t n;
    n.hdr     = h;
    n.on      = (h != 8'd0);
    n.green   = (h == tafd_pkg::ChrA);
    n.left    = (h == tafd_pkg::ChrL || h == tafd_pkg::ChrA || h == tafd_pkg::ChrC);
    n.right   = (h == tafd_pkg::ChrR || h == tafd_pkg::ChrA || h == tafd_pkg::ChrC);
    n.running = (h != tafd_pkg::ChrS || old.hdr == tafd_pkg::ChrS) &&
                (h == tafd_pkg::ChrSpace || t > told);
    n.updated = 1'b0;
    n.updated = ({n.hdr, n.on, n.green, n.left, n.right, n.running} !=
                 {old.hdr, old.on, old.green, old.left, old.right, old.running})
                || old.updated || (t != told);
    return n;
  endfunction

  always_comb begin
    dv_start = 1'b0;
    dv_num   = sabs;
    dv_den   = rres_q;
    if (state_q == S_NDIV) dv_start = 1'b1;
    if (state_q == S_BDIV) begin
      dv_start = 1'b1;
      dv_num   = 32'(run_q) * 32'd2 + 32'(spb1);
      dv_den   = 32'(spb1) * 32'd2;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      spb_q    <= 16'd9408;
      agc_q    <= 16'd66;
      eth_q    <= 15'd2867;
      lth_q    <= 15'd819;
      taps_q   <= 5'd7;
      pow_q    <= 32'h4000_0000;
      for (int i = 0; i < MAX_DELAY; i++) dly_q[i] <= '0;
      ptr_q    <= '0;
      lvl_q    <= 1'b0;
      idle_q   <= 1'b0;
      run_q    <= '0;
      same_q   <= '0;
      sh_q     <= '0;
      bc_q     <= '0;
      st_q     <= '0;
      tv_q     <= '0;
      ovalid_q <= 1'b0;
      mode_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          tafd_pkg::RegBaud:  spb_q  <= cfg_wdata_i;
          tafd_pkg::RegAgc:   agc_q  <= cfg_wdata_i;
          tafd_pkg::RegEdge:  eth_q  <= cfg_wdata_i[14:0];
          tafd_pkg::RegLevel: lth_q  <= cfg_wdata_i[14:0];
          tafd_pkg::RegTaps:  taps_q <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (ovalid_q && m_axis_tready && state_q != S_OUT) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            s_q     <= s_axis_tdata[SAMPLE_BITS-1:0];
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          sq_q    <= sq30;
          state_q <= S_PROD;
        end
        S_PROD: begin
          prod_q  <= pprod;
          state_q <= S_POW;
        end
        S_POW: begin
          if (pnew < 35'sd107374) begin
            pow_q <= tafd_pkg::PowerFloor;
            rx_q  <= tafd_pkg::PowerFloor;
          end else if (pnew > 35'sh0_FFFF_FFFF) begin
            pow_q <= 32'hFFFF_FFFF;
            rx_q  <= 32'hFFFF_FFFF;
          end else begin
            pow_q <= 32'(pnew);
            rx_q  <= 32'(pnew);
          end
          rres_q  <= '0;
          rbit_q  <= 32'h4000_0000;
          rstep_q <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (rx_q >= rsum) begin
            rx_q   <= rx_q - rsum;
            rres_q <= (rres_q >> 1) + rbit_q;
          end else begin
            rres_q <= rres_q >> 1;
          end
          rbit_q  <= rbit_q >> 2;
          rstep_q <= rstep_q + 5'd1;
          if (rstep_q == 5'd15) state_q <= S_NDIV;
        end
        S_NDIV: begin
          neg_q   <= s_q[SAMPLE_BITS-1];
          state_q <= S_NWAIT;
        end
        S_NWAIT: begin
          if (dv_done) begin
            if (neg_q) v_q <= (dv_quo > 32'd32768) ? -16'sd32768 : 16'(-dv_quo);
            else v_q <= (dv_quo > 32'd32767) ? 16'sd32767 : 16'(dv_quo);
            state_q <= S_EDGE;
          end
        end
        S_EDGE: begin
          dly_q[ptr_q] <= v_q;
          ptr_q <= (TW'(ptr_q) + TW'(1) >= taps_eff) ? '0 : DW'(ptr_q + 1'b1);
          mode_q <= edge_w;
          if (edge_w) state_q <= S_BDIV;
          else if (32'(run_q) > 32'(spb1) * 32'd2) begin
            nbits_q <= 8'd1;
            state_q <= S_BIT;
          end else begin
            run_q   <= (run_inc > 25'(tafd_pkg::RunMax)) ? 24'hFF_FFFF : 24'(run_inc);
            state_q <= S_OUT;
          end
        end
        S_BDIV: state_q <= S_BWAIT;
        S_BWAIT: begin
          if (dv_done) begin
            nbits_q <= (dv_quo > tafd_pkg::BitCap) ? 8'(tafd_pkg::BitCap) : 8'(dv_quo);
            state_q <= S_BITS;
          end
        end
        S_BITS: state_q <= (nbits_q == 8'd0) ? S_SUM : S_BIT;
        S_BIT: begin
          same_q <= same_n;
          idle_q <= idle_n;
          if (silence) begin
            st_q <= mk_status(8'd0, '0, st_q, tv_q);
            tv_q <= '0;
          end
          if (frame) begin
            if (bc_n < 4'(PACKET_BYTES)) pk_q[bc_n] <= xw[8:1];
            bc_q <= bc_n + 4'd1;
            sh_q <= idle_n ? 10'h3FF : 10'd0;
          end else begin
            bc_q <= bc_n;
            sh_q <= sh_n;
          end
          nbits_q <= nbits_q - 8'd1;
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (bc_q == 4'd9) begin
            if (sum9 == $signed({4'b0, pk_q[6]})) begin
              bc_q <= '0;
              st_q <= mk_status(pk_q[0], t9, st_q, tv_q);
              tv_q <= t9;
            end
          end else if (bc_q >= 4'd10) begin
            if (sum10 == $signed({4'b0, pk_q[7]})) begin
              st_q <= mk_status(pk_q[0], t10, st_q, tv_q);
              tv_q <= t10;
            end
            bc_q <= '0;
          end
          if (nbits_q != 8'd0 && mode_q) state_q <= S_BIT;
          else begin
            if (mode_q) begin
              lvl_q <= ~lvl_q;
              run_q <= 24'd256;
            end else if (32'(run_q) > 32'(spb1) * 32'd2) begin
              run_q <= (run_dec > 25'(tafd_pkg::RunMax)) ? 24'hFF_FFFF : 24'(run_dec);
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_q || m_axis_tready) begin
            out_q <= {1'b0, st_q.updated, st_q.running, st_q.right, st_q.left, st_q.green,
                      st_q.on, tv_q, st_q.hdr};
            st_q.updated <= 1'b0;
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("output dropped");
  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> (pow_q >= tafd_pkg::PowerFloor)) else $error("power floor");
`endif

endmodule

// ===== tb/tb_timer_audio_frame_decoder_top.sv =====
// Testbench for timer_audio_frame_decoder_top: audio streams of framed timer packets plus noise,
// checked word by word against a bit-exact predictor of the decoder. Depends on tafd_pkg and the top.
`timescale 1ns / 1ps

module tb_timer_audio_frame_decoder_top;

  localparam int unsigned StOn    = 'h100;
  localparam int unsigned StGreen = 'h200;
  localparam int unsigned StLeft  = 'h400;
  localparam int unsigned StRight = 'h800;
  localparam int unsigned StRun   = 'h1000;
  localparam int unsigned StUpd   = 'h2000;
  localparam int unsigned CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = tafd_pkg::RegBaud;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  timer_audio_frame_decoder_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder shadow state
  longint      baud_q88, agc_coef, swing_min, level_min, tap_cfg;
  longint      pwr_est, run_len, dly[16];
  int unsigned dptr, line_lvl, same_run, bits_sh, idle_hi, nbytes, stat_word;
  int unsigned frame[10];
  int          time_val;

  logic [15:0] sample_q[$];
  logic [39:0] status_q[$];
  int          fails = 0;
  int unsigned cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("ERROR %s: got %0d expected %0d", what, got, want);
    fails++;
  endtask

  function automatic int unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 30;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void post_status(input int unsigned hdr, input int t);
    int unsigned ns;
    ns = hdr & 'hff;
    if (hdr != 0) ns |= StOn;
    if (hdr == tafd_pkg::ChrA) ns |= StGreen;
    if (hdr == tafd_pkg::ChrL || hdr == tafd_pkg::ChrA || hdr == tafd_pkg::ChrC) ns |= StLeft;
    if (hdr == tafd_pkg::ChrR || hdr == tafd_pkg::ChrA || hdr == tafd_pkg::ChrC) ns |= StRight;
    if ((hdr != tafd_pkg::ChrS || (stat_word & 'hff) == tafd_pkg::ChrS) &&
        (hdr == tafd_pkg::ChrSpace || t > time_val))
      ns |= StRun;
    if (ns != stat_word || t != time_val) ns |= StUpd;
    stat_word = ns;
    time_val = t;
  endfunction

  function automatic int dig(input int i);
    return int'(frame[i]) - 48;
  endfunction

  function automatic void shift_in_bit(input int unsigned b);
    int unsigned x;
    int          sum;
    if (b == ((bits_sh >> 9) & 1)) begin
      if (same_run < 65535) same_run++;
    end else begin
      same_run = 1;
    end
    bits_sh = ((bits_sh >> 1) & 'h1ff) | (b << 9);
    if (same_run > tafd_pkg::SameLimit) post_status(0, 0);
    if (bits_sh == 0 || bits_sh == 'h3ff) begin
      idle_hi = b;
      nbytes = 0;
    end
    x = bits_sh ^ (idle_hi ? 0 : 'h3ff);
    if ((x & 'h201) == 'h200) begin
      if (nbytes < 10) frame[nbytes] = (x >> 1) & 'hff;
      nbytes++;
      bits_sh = idle_hi ? 'h3ff : 0;
    end
    if (nbytes == 9) begin
      sum = 64 - 240 + int'(frame[1] + frame[2] + frame[3] + frame[4] + frame[5]);
      if (sum == int'(frame[6])) begin
        nbytes = 0;
        post_status(frame[0], dig(1) * 60000 + dig(2) * 10000 + dig(3) * 1000 +
                    dig(4) * 100 + dig(5) * 10);
      end
    end else if (nbytes >= 10) begin
      sum = 64 - 288 + int'(frame[1] + frame[2] + frame[3] + frame[4] + frame[5] + frame[6]);
      if (sum == int'(frame[7]))
        post_status(frame[0], dig(1) * 60000 + dig(2) * 10000 + dig(3) * 1000 +
                    dig(4) * 100 + dig(5) * 10 + dig(6));
      nbytes = 0;
    end
  endfunction

  function automatic logic [39:0] predict_status(input logic [15:0] raw);
    longint      s, spb, prod, pw, v, d, swing, lv, n;
    int unsigned taps, root, ptr;
    bit          hit;
    logic [24:0] t25;
    logic [39:0] w;
    s = longint'($signed(raw));
    spb = baud_q88 ? baud_q88 : 1;
    taps = tap_cfg == 0 ? 1 : (tap_cfg > 16 ? 16 : tap_cfg);
    prod = (s * s - pwr_est) * agc_coef;
    pw = pwr_est + (prod >>> 16);
    if (pw < tafd_pkg::PowerFloor) pw = tafd_pkg::PowerFloor;
    if (pw > 64'hFFFF_FFFF) pw = 64'hFFFF_FFFF;
    pwr_est = pw;
    root = int_sqrt(pwr_est);
    v = (s * 4096) / longint'(root);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    ptr = dptr < 16 ? dptr : 0;
    d = dly[ptr];
    swing = line_lvl ? (d - v) : (v - d);
    lv = line_lvl ? -v : v;
    hit = swing > swing_min && lv > level_min && run_len * 10 > spb * 6;
    dly[ptr] = v;
    dptr = (ptr + 1 >= taps) ? 0 : ptr + 1;
    if (hit) begin
      n = (run_len * 2 + spb) / (2 * spb);
      if (n > tafd_pkg::BitCap) n = tafd_pkg::BitCap;
      for (longint k = 0; k < n; k++) shift_in_bit(line_lvl);
      line_lvl ^= 1;
      run_len = 0;
    end else if (run_len > 2 * spb) begin
      shift_in_bit(line_lvl);
      run_len -= spb;
    end
    run_len = run_len + 256 > tafd_pkg::RunMax ? tafd_pkg::RunMax : run_len + 256;
    t25 = time_val[24:0];
    w = {1'b0, stat_word[13], stat_word[12], stat_word[11], stat_word[10], stat_word[9],
         stat_word[8], t25, stat_word[7:0]};
    stat_word &= ~StUpd;
    return w;
  endfunction

  // sender: bursts with random gaps
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 50);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern (always ready, random ready or rarely ready), re-drawn when its counter runs out
  int unsigned stall_mode, stall_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode <= 0;
      stall_cnt <= 0;
    end else begin
      if (stall_cnt == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_cnt <= $urandom_range(20, 300);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: predict on accepted samples, check accepted status words
  always @(posedge clk_i) begin
    logic [39:0] want;
    if (s_axis_tvalid && s_axis_tready) status_q.push_back(predict_status(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        report("unexpected word", m_axis_tdata, 0);
      end else begin
        want = status_q.pop_front();
        if (m_axis_tdata[7:0] != want[7:0]) report("header_byte", m_axis_tdata[7:0], want[7:0]);
        if (m_axis_tdata[32:8] != want[32:8])
          report("time_ms", $signed(m_axis_tdata[32:8]), $signed(want[32:8]));
        if (m_axis_tdata[33] != want[33]) report("power_on", m_axis_tdata[33], want[33]);
        if (m_axis_tdata[34] != want[34]) report("green_light", m_axis_tdata[34], want[34]);
        if (m_axis_tdata[35] != want[35]) report("left_hand", m_axis_tdata[35], want[35]);
        if (m_axis_tdata[36] != want[36]) report("right_hand", m_axis_tdata[36], want[36]);
        if (m_axis_tdata[37] != want[37]) report("running", m_axis_tdata[37], want[37]);
        if (m_axis_tdata[38] != want[38]) report("updated", m_axis_tdata[38], want[38]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val[15:0];
    case (idx)
      tafd_pkg::RegBaud:  baud_q88 = val & 'hffff;
      tafd_pkg::RegAgc:   agc_coef = val & 'hffff;
      tafd_pkg::RegEdge:  swing_min = val & 'h7fff;
      tafd_pkg::RegLevel: level_min = val & 'h7fff;
      tafd_pkg::RegTaps:  tap_cfg = val & 'h1f;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned baud, agc, edg, lvl, taps);
    write_reg(tafd_pkg::RegBaud, baud);
    write_reg(tafd_pkg::RegAgc, agc);
    write_reg(tafd_pkg::RegEdge, edg);
    write_reg(tafd_pkg::RegLevel, lvl);
    write_reg(tafd_pkg::RegTaps, taps);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_level(input bit b, input int amp, input int count);
    int val;
    for (int i = 0; i < count; i++) begin
      val = (b ? amp : -amp) + int'($urandom_range(0, 511)) - 256;
      sample_q.push_back(val[15:0]);
    end
  endtask

  // one serial frame: idle high, 8N1 bytes LSB first, optional single bit error
  task automatic add_packet(input bit short_form, input bit corrupt, input int spb_smp);
    int unsigned pkt[10];
    bit          bitq[$];
    int          len, sum, amp, flip;
    case ($urandom_range(0, 6))
      0: pkt[0] = tafd_pkg::ChrA;
      1: pkt[0] = tafd_pkg::ChrC;
      2: pkt[0] = tafd_pkg::ChrL;
      3: pkt[0] = tafd_pkg::ChrR;
      4: pkt[0] = tafd_pkg::ChrS;
      5: pkt[0] = tafd_pkg::ChrSpace;
      default: pkt[0] = $urandom_range(0, 255);
    endcase
    len = short_form ? 9 : 10;
    sum = 64 - (short_form ? 240 : 288);
    for (int i = 1; i <= (short_form ? 5 : 6); i++) begin
      pkt[i] = 48 + $urandom_range(0, 9);
      sum += pkt[i];
    end
    pkt[short_form ? 6 : 7] = sum;
    pkt[len - 2] = 13;
    pkt[len - 1] = 10;
    for (int i = 0; i < 11; i++) bitq.push_back(1'b1);
    for (int i = 0; i < len; i++) begin
      bitq.push_back(1'b0);
      for (int j = 0; j < 8; j++) bitq.push_back(pkt[i][j]);
      bitq.push_back(1'b1);
    end
    bitq.push_back(1'b1);
    if (corrupt) begin
      flip = $urandom_range(11, bitq.size() - 2);
      bitq[flip] = !bitq[flip];
    end
    amp = $urandom_range(6000, 30000);
    foreach (bitq[i]) add_level(bitq[i], amp, spb_smp);
  endtask

  task automatic add_noise(input int count);
    for (int i = 0; i < count; i++) sample_q.push_back($urandom_range(0, 65535));
  endtask

  initial begin
    baud_q88 = 9408;
    agc_coef = 66;
    swing_min = 2867;
    level_min = 819;
    tap_cfg = 7;
    pwr_est = 64'd1 << 30;
    foreach (dly[i]) dly[i] = 0;
    foreach (frame[i]) frame[i] = 0;
    dptr = 0;
    line_lvl = 0;
    run_len = 0;
    same_run = 0;
    bits_sh = 0;
    idle_hi = 0;
    nbytes = 0;
    stat_word = 0;
    time_val = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes with reset settings
    sample_q.push_back(16'h7fff);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'hffff);
    sample_q.push_back(16'h0001);
    sample_q.push_back(16'h5555);
    sample_q.push_back(16'haaaa);
    for (int i = 0; i < 6; i++) begin
      sample_q.push_back(16'h7fff);
      sample_q.push_back(16'h8000);
    end
    add_noise(40);
    drain();

    // two samples per bit: framed packets
    set_regs(512, 8000, 2867, 819, 1);
    add_packet(1'b0, 1'b0, 2);
    add_packet(1'b1, 1'b0, 2);
    add_packet(1'b0, 1'b1, 2);
    drain();

    // zero baud, zero taps, zero thresholds, fastest tracking
    set_regs(0, 65535, 0, 0, 0);
    add_noise(30);
    drain();

    // slowest baud, frozen power, top thresholds, taps past the line length
    set_regs(65535, 0, 32767, 32767, 31);
    add_noise(30);
    drain();

    // long run ending in an edge: run-out bits during the level, idle drop to off
    set_regs(256, 1000, 2867, 819, 16);
    add_level(1'b1, 20000, 170);
    add_level(1'b0, 20000, 20);
    add_noise(20);
    drain();

    repeat (300) @(posedge clk_i);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tafd_pkg.sv
hw/rtl/tafd_div.sv
hw/rtl/timer_audio_frame_decoder_top.sv
tb/tb_timer_audio_frame_decoder_top.sv
